@@ hw/rtl/rcf_pkg.sv @@
// rcf_pkg: shared types, constants, command codes and twiddle tables
// for the radix-2 complex FFT. No dependencies.
`default_nettype none
package rcf_pkg;

  localparam int MAX_LOG2_SIZE = 8;
  localparam int SAMPLE_WIDTH  = 24;
  localparam int TWIDDLE_WIDTH = 16;
  localparam int TW_FRAC       = TWIDDLE_WIDTH - 2;
  localparam int MAX_POINTS    = 1 << MAX_LOG2_SIZE;
  localparam int ADDR_W        = MAX_LOG2_SIZE;
  localparam int CNT_W         = ADDR_W + 1;
  localparam int STG_W         = $clog2(MAX_LOG2_SIZE);
  localparam int WORD_W        = 32;
  localparam int LOG2_W        = 4;

  // quarter-wave geometry of the twiddle tables
  localparam int  QS_LOG2 = MAX_LOG2_SIZE - 2;
  localparam int  QS      = 1 << QS_LOG2;
  localparam real TW_STEP = 6.283185307179586 / MAX_POINTS;

  typedef logic signed [TWIDDLE_WIDTH-1:0] tw_t;
  typedef tw_t [MAX_POINTS-1:0] tw_tab_t;

  typedef struct packed {
    logic                           func;
    logic signed [SAMPLE_WIDTH-1:0] sample_re;
    logic signed [SAMPLE_WIDTH-1:0] sample_im;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] out_re;
    logic signed [WORD_W-1:0] out_im;
    logic                     last;
  } out_item_t;

  // input function codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_READ, OP_RA, OP_RB, OP_M1, OP_M2, OP_TW, OP_BF, OP_WA, OP_WB
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RA, ST_RB, ST_M1, ST_M2, ST_TW, ST_BF, ST_WA, ST_WB
  } state_e;

  typedef struct packed {
    op_e               op;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
    logic [ADDR_W-1:0] tw_idx;
    logic              last;
  } cmd_t;

  // quarter-wave magnitudes, rounded half away from zero
  function automatic tw_tab_t build_tw(input bit want_sin);
    tw_tab_t t;
    int      q, r, c, s;
    real     x;
    for (int k = 0; k < MAX_POINTS; k++) begin
      q = k >> QS_LOG2;
      r = k & (QS - 1);
      x = TW_STEP * r;
      c = int'($cos(x) * (1 << TW_FRAC));
      s = int'($sin(x) * (1 << TW_FRAC));
      case (q)
        0: t[k] = want_sin ? tw_t'(s) : tw_t'(c);
        1: t[k] = want_sin ? tw_t'(c) : tw_t'(-s);
        2: t[k] = want_sin ? tw_t'(-s) : tw_t'(-c);
        default: t[k] = want_sin ? tw_t'(-c) : tw_t'(s);
      endcase
    end
    return t;
  endfunction

  localparam tw_tab_t TW_COS = build_tw(1'b0);
  localparam tw_tab_t TW_SIN = build_tw(1'b1);

endpackage
`default_nettype wire

@@ hw/rtl/rcf_datapath.sv @@
// rcf_datapath: point memory, twiddle lookup and butterfly arithmetic.
// Depends on rcf_pkg; driven by rcf_ctrl commands.
`default_nettype none
module rcf_datapath (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  rcf_pkg::cmd_t          cmd_i,
  input  rcf_pkg::in_item_t      in_i,
  output logic                   res_valid_o,
  output rcf_pkg::out_item_t     res_o
);
  localparam int W   = rcf_pkg::WORD_W;
  localparam int PW  = W + rcf_pkg::TWIDDLE_WIDTH;
  localparam int SW  = PW + 1;
  localparam int TRW = SW - rcf_pkg::TW_FRAC;
  localparam int OW  = TRW + 1;

  logic [2*W-1:0] mem_q [rcf_pkg::MAX_POINTS];
  logic [2*W-1:0] rd_q;
  logic [rcf_pkg::ADDR_W-1:0] rd_addr, wr_addr;
  logic [2*W-1:0] wr_data;
  logic           rd_en, wr_en;

  logic signed [W-1:0]   a_re_q, a_im_q, b_re, b_im;
  logic signed [PW-1:0]  p0_q, p1_q, p2_q, p3_q;
  logic signed [TRW-1:0] tr_q, ti_q;
  logic signed [W-1:0]   ar_o_q, ai_o_q, br_o_q, bi_o_q;
  logic signed [rcf_pkg::TWIDDLE_WIDTH-1:0] c_w, s_w;
  logic                  valid_q, last_q;

  function automatic logic signed [W-1:0] sat(input logic signed [OW-1:0] v);
    logic signed [OW-1:0] hi, lo;
    hi = OW'({1'b0, {(W-1){1'b1}}});
    lo = -hi - OW'(1);
    if (v > hi) return {1'b0, {(W-1){1'b1}}};
    if (v < lo) return {1'b1, {(W-1){1'b0}}};
    return v[W-1:0];
  endfunction

  assign b_re = rd_q[2*W-1:W];
  assign b_im = rd_q[W-1:0];
  assign c_w  = rcf_pkg::TW_COS[cmd_i.tw_idx];
  assign s_w  = rcf_pkg::TW_SIN[cmd_i.tw_idx];

  // memory port selection
  always_comb begin
    rd_en   = (cmd_i.op == rcf_pkg::OP_READ) || (cmd_i.op == rcf_pkg::OP_RA) ||
              (cmd_i.op == rcf_pkg::OP_RB);
    rd_addr = (cmd_i.op == rcf_pkg::OP_RB) ? cmd_i.addr_b : cmd_i.addr_a;
    wr_en   = 1'b0;
    wr_addr = cmd_i.addr_a;
    wr_data = {ar_o_q, ai_o_q};
    case (cmd_i.op)
      rcf_pkg::OP_LOAD: begin
        wr_en   = 1'b1;
        wr_data = {W'(in_i.sample_re), W'(in_i.sample_im)};
      end
      rcf_pkg::OP_WA: wr_en = 1'b1;
      rcf_pkg::OP_WB: begin
        wr_en   = 1'b1;
        wr_addr = cmd_i.addr_b;
        wr_data = {br_o_q, bi_o_q};
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem_q[rd_addr];
  end

  // butterfly pipeline registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      rcf_pkg::OP_RB: begin
        a_re_q <= rd_q[2*W-1:W];
        a_im_q <= rd_q[W-1:0];
      end
      rcf_pkg::OP_M1: begin
        p0_q <= PW'(b_re) * PW'(c_w);
        p1_q <= PW'(b_im) * PW'(s_w);
      end
      rcf_pkg::OP_M2: begin
        p2_q <= PW'(b_re) * PW'(s_w);
        p3_q <= PW'(b_im) * PW'(c_w);
      end
      rcf_pkg::OP_TW: begin
        tr_q <= TRW'((SW'(p0_q) - SW'(p1_q) + (SW'(1) <<< (rcf_pkg::TW_FRAC-1)))
                >>> rcf_pkg::TW_FRAC);
        ti_q <= TRW'((SW'(p2_q) + SW'(p3_q) + (SW'(1) <<< (rcf_pkg::TW_FRAC-1)))
                >>> rcf_pkg::TW_FRAC);
      end
      rcf_pkg::OP_BF: begin
        ar_o_q <= sat(OW'(a_re_q) + OW'(tr_q));
        ai_o_q <= sat(OW'(a_im_q) + OW'(ti_q));
        br_o_q <= sat(OW'(a_re_q) - OW'(tr_q));
        bi_o_q <= sat(OW'(a_im_q) - OW'(ti_q));
      end
      default: ;
    endcase
  end

  // read result strobe, registered with the memory read data in the cycle after the read command
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      valid_q <= (cmd_i.op == rcf_pkg::OP_READ);
      last_q  <= cmd_i.last;
    end
  end

  assign res_valid_o   = valid_q;
  assign res_o.out_re  = rd_q[2*W-1:W];
  assign res_o.out_im  = rd_q[W-1:0];
  assign res_o.last    = last_q;
endmodule
`default_nettype wire

@@ hw/rtl/rcf_ctrl.sv @@
// rcf_ctrl: frame counters, size register and butterfly sequencer.
// Depends on rcf_pkg; issues commands to rcf_datapath.
`default_nettype none
module rcf_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start,
  input  wire                 func_i,
  input  wire                 cfg_we_i,
  input  wire [3:0]           cfg_data_i,
  output logic                busy,
  output rcf_pkg::cmd_t       cmd_o
);
  localparam int AW = rcf_pkg::ADDR_W;
  localparam int CW = rcf_pkg::CNT_W;
  localparam int SG = rcf_pkg::STG_W;

  rcf_pkg::state_e state_q, state_d;
  logic [rcf_pkg::LOG2_W-1:0] log2_q;
  logic [CW-1:0] load_q, load_d, read_q, read_d;
  logic          ready_q, ready_d;
  logic [SG-1:0] stg_q, stg_d;
  logic [AW-2:0] bfy_q, bfy_d;
  logic [SG:0]   bits;
  logic [CW-1:0] npts, lidx;
  logic [AW-1:0] mext, lmask, jidx, addr_a, addr_b, brev;
  logic          xf_done;

  // clamped transform size
  always_comb begin
    if (log2_q < rcf_pkg::LOG2_W'(2)) bits = (SG+1)'(2);
    else if (log2_q > rcf_pkg::LOG2_W'(rcf_pkg::MAX_LOG2_SIZE))
      bits = (SG+1)'(rcf_pkg::MAX_LOG2_SIZE);
    else bits = (SG+1)'(log2_q);
    npts = CW'(1) << bits;
  end

  // load index and its bit-reversed address
  always_comb begin
    lidx = (ready_q || load_q >= npts) ? '0 : load_q;
    for (int i = 0; i < AW; i++) brev[i] = lidx[AW-1-i];
    brev = brev >> (AW - int'(bits));
  end

  // butterfly addressing
  always_comb begin
    mext    = {1'b0, bfy_q};
    lmask   = (AW'(1) << stg_q) - AW'(1);
    jidx    = mext & lmask;
    addr_a  = ((mext & ~lmask) << 1) | jidx;
    addr_b  = addr_a | (AW'(1) << stg_q);
    xf_done = (CW'(bfy_q) == (npts >> 1) - CW'(1)) && ((SG+1)'(stg_q) == bits - (SG+1)'(1));
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rcf_pkg::ST_IDLE:
        if (start && func_i == rcf_pkg::FUNC_LOAD && lidx + CW'(1) == npts)
          state_d = rcf_pkg::ST_RA;
      rcf_pkg::ST_RA: state_d = rcf_pkg::ST_RB;
      rcf_pkg::ST_RB: state_d = rcf_pkg::ST_M1;
      rcf_pkg::ST_M1: state_d = rcf_pkg::ST_M2;
      rcf_pkg::ST_M2: state_d = rcf_pkg::ST_TW;
      rcf_pkg::ST_TW: state_d = rcf_pkg::ST_BF;
      rcf_pkg::ST_BF: state_d = rcf_pkg::ST_WA;
      rcf_pkg::ST_WA: state_d = rcf_pkg::ST_WB;
      rcf_pkg::ST_WB: state_d = xf_done ? rcf_pkg::ST_IDLE : rcf_pkg::ST_RA;
      default: state_d = rcf_pkg::ST_IDLE;
    endcase
  end

  // commands and counter updates
  always_comb begin
    cmd_o.op     = rcf_pkg::OP_NONE;
    cmd_o.addr_a = addr_a;
    cmd_o.addr_b = addr_b;
    cmd_o.tw_idx = AW'(jidx << (AW - 1 - int'(stg_q)));
    cmd_o.last   = 1'b0;
    load_d = load_q;
    read_d = read_q;
    ready_d = ready_q;
    stg_d = stg_q;
    bfy_d = bfy_q;
    busy = (state_q != rcf_pkg::ST_IDLE);
    case (state_q)
      rcf_pkg::ST_IDLE: begin
        if (start && func_i == rcf_pkg::FUNC_LOAD) begin
          cmd_o.op     = rcf_pkg::OP_LOAD;
          cmd_o.addr_a = brev;
          load_d       = lidx + CW'(1);
          ready_d      = 1'b0;
          read_d       = '0;
          stg_d        = '0;
          bfy_d        = '0;
        end else if (start && ready_q) begin
          cmd_o.op     = rcf_pkg::OP_READ;
          cmd_o.addr_a = read_q[AW-1:0];
          cmd_o.last   = (read_q + CW'(1) >= npts);
          read_d       = read_q + CW'(1);
          if (cmd_o.last) begin
            ready_d = 1'b0;
            read_d  = '0;
            load_d  = '0;
          end
        end
      end
      rcf_pkg::ST_RA: cmd_o.op = rcf_pkg::OP_RA;
      rcf_pkg::ST_RB: cmd_o.op = rcf_pkg::OP_RB;
      rcf_pkg::ST_M1: cmd_o.op = rcf_pkg::OP_M1;
      rcf_pkg::ST_M2: cmd_o.op = rcf_pkg::OP_M2;
      rcf_pkg::ST_TW: cmd_o.op = rcf_pkg::OP_TW;
      rcf_pkg::ST_BF: cmd_o.op = rcf_pkg::OP_BF;
      rcf_pkg::ST_WA: cmd_o.op = rcf_pkg::OP_WA;
      rcf_pkg::ST_WB: begin
        cmd_o.op = rcf_pkg::OP_WB;
        if (xf_done) begin
          ready_d = 1'b1;
          read_d  = '0;
        end else if (CW'(bfy_q) == (npts >> 1) - CW'(1)) begin
          bfy_d = '0;
          stg_d = stg_q + SG'(1);
        end else begin
          bfy_d = bfy_q + (AW-1)'(1);
        end
      end
      default: cmd_o.op = rcf_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rcf_pkg::ST_IDLE;
      log2_q  <= rcf_pkg::LOG2_W'(rcf_pkg::MAX_LOG2_SIZE);
      load_q  <= '0;
      read_q  <= '0;
      ready_q <= 1'b0;
      stg_q   <= '0;
      bfy_q   <= '0;
    end else if (cfg_we_i) begin
      log2_q  <= cfg_data_i;
      load_q  <= '0;
      read_q  <= '0;
      ready_q <= 1'b0;
    end else begin
      state_q <= state_d;
      load_q  <= load_d;
      read_q  <= read_d;
      ready_q <= ready_d;
      stg_q   <= stg_d;
      bfy_q   <= bfy_d;
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/radix2_complex_fft.sv @@
// radix2_complex_fft: top level of the in-place radix-2 inverse FFT.
// Depends on rcf_pkg, rcf_ctrl and rcf_datapath.
//
//  channel   signals                         transfer
//  input     start, busy, in_i               start && !busy at clk edge
//  result    res_valid_o, res_o              one-cycle strobe, cannot stall
//  config    cfg_we_i, cfg_data_i            cfg_we_i at clk edge
//
// Loads and reads can be accepted back to back while idle; a read's result is
// strobed the next cycle. The frame-completing load starts the transform on
// the shared butterfly unit and single-port-write memory, (N/2)*log2(N)
// butterflies, busy high meanwhile. Reset clears counters; memory is kept.
`default_nettype none
module radix2_complex_fft (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start,
  output logic                busy,
  input  rcf_pkg::in_item_t   in_i,
  output logic                res_valid_o,
  output rcf_pkg::out_item_t  res_o,
  input  wire                 cfg_we_i,
  input  wire [3:0]           cfg_data_i
);
  rcf_pkg::cmd_t cmd;

  rcf_ctrl u_ctrl (
    .clk_i, .rst_ni, .start, .func_i(in_i.func), .cfg_we_i, .cfg_data_i,
    .busy, .cmd_o(cmd)
  );

  rcf_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .in_i, .res_valid_o, .res_o
  );

  // a result strobe follows an accepted read and never overlaps a transform
  a_res_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(start && !busy && in_i.func == rcf_pkg::FUNC_READ))
    else $error("result without read");
  a_res_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !busy)
    else $error("result during transform");
  a_busy_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start && in_i.func == rcf_pkg::FUNC_LOAD))
    else $error("transform without load");
endmodule
`default_nettype wire
